// ===== rtl/bdqs_pkg.sv =====
`timescale 1ns / 1ps

package bdqs_pkg;

    // Default number of entries the queue can hold.
    localparam int CAPACITY_DEF = 16;

    // Widths of the request and result fields.
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // One request.
    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // One result.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

    // Controls broadcast from the top level to every cell.
    typedef struct packed {
        logic              accept;
        logic              push_front;
        logic              pop_front;
        logic              search;
        logic [DATA_W-1:0] value;
    } ctrl_t;

endpackage

// ===== rtl/bdqs_cell.sv =====
`timescale 1ns / 1ps

module bdqs_cell (
    input  logic                            clk,
    input  bdqs_pkg::ctrl_t                 ctrl,
    input  logic [bdqs_pkg::DATA_W-1:0]     front_data,
    input  logic [bdqs_pkg::DATA_W-1:0]     back_data,
    input  logic                            occupied,
    input  logic                            load_back,
    output logic [bdqs_pkg::DATA_W-1:0]     data,
    output logic                            match
);
    import bdqs_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match_reg;
    logic              match_next;

    // A front push shifts every entry one cell toward the back, a front pop
    // shifts them one cell toward the front, and a back push writes only the
    // cell just past the last held entry.
    always_comb
    begin
        if (ctrl.push_front)
        begin
            data_next = front_data;
        end
        else if (ctrl.pop_front)
        begin
            data_next = back_data;
        end
        else if (load_back)
        begin
            data_next = ctrl.value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // Compare the held entry against the search word.
    assign match_next = ctrl.search && occupied && (data_reg == ctrl.value);

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            data_reg  <= data_next;
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== rtl/bounded_deque_with_search_core.sv =====
`timescale 1ns / 1ps
// Pipeline: a request is held in the first stage, then in the output register.
// Throughput: one request per cycle while the result side does not stall;
// the cell row updates and compares every entry in the cycle of acceptance.
// Reset: asynchronous, active low; clears the entry count and both pipeline
// stages. Cell contents are not reset and are read only after being written.

module bounded_deque_with_search_core #(
    parameter int CAPACITY = bdqs_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bdqs_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bdqs_pkg::rsp_t  rsp
);
    import bdqs_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                req_accept;
    logic                s1_adv;
    logic                is_full;
    logic                is_empty;
    ctrl_t               ctrl;

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [STATUS_W-1:0] s1_status_reg;
    logic [STATUS_W-1:0] s1_status_next;
    logic [COUNT_W-1:0]  s1_count_reg;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_reg;

    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY-1:0] match_vec;

    // Handshake: the first stage moves on when the output register is free.
    assign s1_adv     = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !s1_adv;
    assign req_accept = req_valid && !req_stall;

    assign is_full  = (cnt_reg == CNT_W'(CAPACITY));
    assign is_empty = (cnt_reg == '0);

    // Decode the command into cell controls, next count and status.
    always_comb
    begin
        ctrl.accept     = req_accept;
        ctrl.push_front = 1'b0;
        ctrl.pop_front  = 1'b0;
        ctrl.search     = 1'b0;
        ctrl.value      = req.value;
        cnt_next        = cnt_reg;
        s1_status_next  = ST_OK;
        unique case (req.command)
            CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    s1_status_next = ST_FULL;
                end
                else
                begin
                    ctrl.push_front = req_accept;
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    s1_status_next = ST_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (is_empty)
                begin
                    s1_status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl.pop_front = req_accept;
                    cnt_next       = cnt_reg - 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (is_empty)
                begin
                    s1_status_next = ST_EMPTY;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                ctrl.search = req_accept;
            end
            default:
            begin
            end
        endcase
    end

    // The row of cells; cell zero holds the front entry.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] front_data;
        logic [DATA_W-1:0] back_data;
        logic              occupied;
        logic              load_back;

        if (i == 0)
        begin : g_first
            assign front_data = req.value;
        end
        else
        begin : g_inner
            assign front_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign back_data = cell_data[i];
        end
        else
        begin : g_mid
            assign back_data = cell_data[i+1];
        end

        assign occupied  = (CNT_W'(i) < cnt_reg);
        assign load_back = req_accept && (req.command == CMD_PUSH_BACK) && !is_full
                           && (cnt_reg == CNT_W'(i));

        bdqs_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .front_data (front_data),
            .back_data  (back_data),
            .occupied   (occupied),
            .load_back  (load_back),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );
    end

    // The count field keeps the low bits of the entry count.
    assign cnt_wide = {{COUNT_W{1'b0}}, cnt_next};

    always_comb
    begin
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Entry count and first-stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (req_accept)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // First-stage result fields.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_status_reg <= s1_status_next;
            s1_count_reg  <= cnt_wide[COUNT_W-1:0];
        end
    end

    // Output register: the match bits of all cells are merged here.
    always_comb
    begin
        if (s1_adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            rsp_reg.status <= s1_status_reg;
            rsp_reg.found  <= |match_vec;
            rsp_reg.count  <= s1_count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
